// File: hw/rtl/meter_reply_frame_checker_top_defines.svh
// Assertion macros for the meter reply frame checker.
// Used by meter_reply_frame_checker_top.sv; depends on nothing else.
`ifndef METER_REPLY_FRAME_CHECKER_TOP_DEFINES_SVH
`define METER_REPLY_FRAME_CHECKER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define MRFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mrfc assertion failed");

// next-cycle implication, off during reset
`define MRFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mrfc assertion failed");

`endif

// File: hw/rtl/mrfc_pkg.sv
// Package for the meter reply frame checker: widths, frame constants, status codes.
// No dependencies.
`timescale 1ns / 1ps

package mrfc_pkg;

	localparam int BYTE_W     = 8;
	localparam int ADDR_W     = 48;
	localparam int STATUS_W   = 3;
	localparam int POS_W      = 4;

	localparam int MIN_FRAME_BYTES_DEFAULT = 12;

	localparam logic [BYTE_W-1:0] START_MARK   = 8'h68;
	localparam logic [BYTE_W-1:0] STOP_MARK    = 8'h16;
	localparam logic [POS_W-1:0]  FIRST_POS    = 4'd0;
	localparam logic [POS_W-1:0]  SECOND_START_POS = 4'd7;
	localparam logic [POS_W-1:0]  CONTROL_POS  = 4'd8;
	localparam logic [POS_W-1:0]  POS_MAX      = 4'd15;
	localparam int DIR_BIT      = 7;
	localparam int ABNORMAL_BIT = 6;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_MARKERS  = 3'd2,
		ST_CHECKSUM = 3'd3,
		ST_DIRECTION = 3'd4,
		ST_ABNORMAL = 3'd5,
		ST_ADDRESS  = 3'd6
	} status_t;

endpackage

// File: hw/rtl/mrfc_if.sv
// Handshake interfaces for the frame checker: input byte, result and config write.
// Depends on mrfc_pkg.
`timescale 1ns / 1ps

interface mrfc_in_if import mrfc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic              is_last;
	modport source (output valid, output frame_byte, output is_last, input ready);
	modport sink (input valid, input frame_byte, input is_last, output ready);
endinterface

interface mrfc_out_if import mrfc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   error_byte;
	modport source (output valid, output status, output error_byte, input ready);
	modport sink (input valid, input status, input error_byte, output ready);
endinterface

interface mrfc_cfg_if import mrfc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] station_address;
	modport source (output valid, output station_address, input ready);
	modport sink (input valid, input station_address, output ready);
endinterface

// File: hw/rtl/meter_reply_frame_checker_top.sv
// Meter reply frame checker: byte-wise frame validation with one verdict per frame.
// A word enters the input register; the result register takes the verdict as the last
// word leaves it. Throughput: one word per cycle while no last word waits on an unaccepted
// verdict, set by the update of the per-frame state from the input register.
// Reset (arst_n low, asynchronous) clears frame state, address and both valid flags.
// Depends on mrfc_pkg, mrfc_if.sv and meter_reply_frame_checker_top_defines.svh.
`timescale 1ns / 1ps
`include "meter_reply_frame_checker_top_defines.svh"

module meter_reply_frame_checker_top import mrfc_pkg::*; #(
	parameter int MIN_FRAME_BYTES = MIN_FRAME_BYTES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	mrfc_in_if.sink     in_ch,
	mrfc_out_if.source  out_ch,
	mrfc_cfg_if.sink    cfg
);

	localparam logic [POS_W-1:0] SHORT_LIMIT = POS_W'(MIN_FRAME_BYTES - 1);

	logic [ADDR_W-1:0] addr_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] rb0_q;
	logic [BYTE_W-1:0] rb1_q;
	logic [BYTE_W-1:0] ctrl_q;
	logic              start_ok_q;
	logic              addr_ok_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [BYTE_W-1:0]   err_q;

	logic              adv_s1;
	logic [BYTE_W-1:0] want;
	logic              in_addr;
	logic              start_ok_n;
	logic              addr_ok_n;
	logic [BYTE_W-1:0] ctrl_n;
	status_t           status_n;
	logic [BYTE_W-1:0] err_n;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			addr_q <= cfg.station_address;
		end
	end

	assign adv_s1      = valid_s1 && (!last_s1 || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.frame_byte;
			last_s1 <= in_ch.is_last;
		end
	end

	always_comb begin
		unique case (pos_q)
			4'd1:    want = addr_q[7:0];
			4'd2:    want = addr_q[15:8];
			4'd3:    want = addr_q[23:16];
			4'd4:    want = addr_q[31:24];
			4'd5:    want = addr_q[39:32];
			4'd6:    want = addr_q[47:40];
			default: want = '0;
		endcase
	end

	assign in_addr    = (pos_q >= 4'd1) && (pos_q <= 4'd6);
	assign start_ok_n = start_ok_q &&
		!(((pos_q == FIRST_POS) || (pos_q == SECOND_START_POS)) && (byte_s1 != START_MARK));
	assign addr_ok_n  = addr_ok_q && !(in_addr && (byte_s1 != want));
	assign ctrl_n     = (pos_q == CONTROL_POS) ? byte_s1 : ctrl_q;

	always_comb begin
		err_n = '0;
		priority if (pos_q < SHORT_LIMIT) begin
			status_n = ST_SHORT;
		end else if (!start_ok_n || (byte_s1 != STOP_MARK)) begin
			status_n = ST_MARKERS;
		end else if (sum_q != rb0_q) begin
			status_n = ST_CHECKSUM;
		end else if (!ctrl_n[DIR_BIT]) begin
			status_n = ST_DIRECTION;
		end else if (ctrl_n[ABNORMAL_BIT]) begin
			status_n = ST_ABNORMAL;
			err_n    = rb1_q;
		end else if (!addr_ok_n) begin
			status_n = ST_ADDRESS;
		end else begin
			status_n = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			sum_q      <= '0;
			rb0_q      <= '0;
			rb1_q      <= '0;
			ctrl_q     <= '0;
			start_ok_q <= 1'b1;
			addr_ok_q  <= 1'b1;
		end else if (adv_s1) begin
			if (last_s1) begin
				pos_q      <= '0;
				sum_q      <= '0;
				rb0_q      <= '0;
				rb1_q      <= '0;
				ctrl_q     <= '0;
				start_ok_q <= 1'b1;
				addr_ok_q  <= 1'b1;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 4'd1;
				end
				sum_q      <= sum_q + rb0_q;
				rb0_q      <= byte_s1;
				rb1_q      <= rb0_q;
				ctrl_q     <= ctrl_n;
				start_ok_q <= start_ok_n;
				addr_ok_q  <= addr_ok_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			status_q <= status_n;
			err_q    <= err_n;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.status     = status_q;
	assign out_ch.error_byte = err_q;

	`MRFC_ASSERT_SAME(a_status_range, clk, arst_n, out_ch.valid, out_ch.status != 3'd7)
	`MRFC_ASSERT_SAME(a_err_only_abnormal, clk, arst_n, out_ch.valid && (out_ch.error_byte != '0),
		out_ch.status == ST_ABNORMAL)
	`MRFC_ASSERT_NEXT(a_frame_clear, clk, arst_n, adv_s1 && last_s1,
		(pos_q == '0) && (sum_q == '0) && start_ok_q && addr_ok_q)
	`MRFC_ASSERT_SAME(a_stall_cause, clk, arst_n, !in_ch.ready,
		valid_s1 && last_s1 && out_valid_q && !out_ch.ready)

endmodule

// File: dv/testbench.sv
// Testbench for meter_reply_frame_checker_top: directed and random reply frames, with
// per-frame verdicts predicted in the bench and checked as they come out.
// Depends on mrfc_pkg, mrfc_if.sv and the checker RTL.
`timescale 1ns / 1ps

module testbench import mrfc_pkg::*; ();

	localparam int ADDR_BYTES = 6;
	localparam int MIN_FRAME = MIN_FRAME_BYTES_DEFAULT;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 80;
	localparam int SETTLE_CYCLES = 6;

	typedef struct packed {
		status_t          status;
		logic [BYTE_W-1:0] err;
	} verdict_t;

	typedef struct {
		int unsigned       len;
		logic [BYTE_W-1:0] ctrl;
		logic [BYTE_W-1:0] fill;
		bit                noise;
		bit                rand_data;
		bit                bad_addr;
		bit                bad_first;
		bit                bad_second;
		bit                bad_stop;
		bit                bad_sum;
		bit                typed;
		status_t           status;
		logic [BYTE_W-1:0] err;
	} recipe_t;

	logic clk;
	logic arst_n;

	mrfc_in_if  in_ch ();
	mrfc_out_if out_ch ();
	mrfc_cfg_if cfg_ch ();

	meter_reply_frame_checker_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	// frame state of the bench's own checker
	logic [POS_W-1:0]  seen_cnt;
	logic [BYTE_W-1:0] sum_acc;
	logic [BYTE_W-1:0] hist [3];
	logic [BYTE_W-1:0] ctrl_seen;
	bit                markers_ok;
	bit                addr_ok;
	logic [ADDR_W-1:0] addr_reg;

	verdict_t    pending_verdicts [$];
	int unsigned fail_count;
	int unsigned cycle_count;
	bit          no_idle;
	bit          hold_req;

	recipe_t directed_frames [0:12] = '{
		'{1,  8'h00, 8'hFF, 1, 0, 0, 0, 0, 0, 0, 1, ST_SHORT,     8'h00},
		'{11, 8'h80, 8'h00, 0, 0, 0, 0, 0, 0, 0, 1, ST_SHORT,     8'h00},
		'{12, 8'h80, 8'h00, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK,        8'h00},
		'{12, 8'h80, 8'h00, 0, 0, 0, 1, 0, 0, 0, 1, ST_MARKERS,   8'h00},
		'{12, 8'h80, 8'h00, 0, 0, 0, 0, 1, 0, 0, 1, ST_MARKERS,   8'h00},
		'{12, 8'h80, 8'h00, 0, 0, 0, 0, 0, 1, 0, 1, ST_MARKERS,   8'h00},
		'{12, 8'h80, 8'h00, 0, 0, 0, 0, 0, 0, 1, 1, ST_CHECKSUM,  8'h00},
		'{12, 8'h7F, 8'h00, 0, 0, 0, 0, 0, 0, 0, 1, ST_DIRECTION, 8'h00},
		'{13, 8'hC0, 8'hA5, 0, 0, 0, 0, 0, 0, 0, 1, ST_ABNORMAL,  8'hA5},
		'{12, 8'h80, 8'h00, 0, 0, 1, 0, 0, 0, 0, 1, ST_ADDRESS,   8'h00},
		'{24, 8'hBF, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK,        8'h00},
		'{12, 8'hFF, 8'h00, 0, 0, 1, 0, 0, 0, 0, 0, ST_OK,        8'h00},
		'{14, 8'h00, 8'h5A, 0, 1, 0, 0, 0, 0, 1, 0, ST_OK,        8'h00}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (fail_count < 50)
			$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic void clear_frame_state();
		seen_cnt = '0;
		sum_acc = '0;
		hist[0] = '0;
		hist[1] = '0;
		hist[2] = '0;
		ctrl_seen = '0;
		markers_ok = 1'b1;
		addr_ok = 1'b1;
	endfunction

	function automatic bit judge_byte(input logic [BYTE_W-1:0] b, input bit last_flag,
			output verdict_t v);
		int p;
		p = int'(seen_cnt);
		v.status = ST_OK;
		v.err = '0;
		if (seen_cnt == FIRST_POS && b != START_MARK)
			markers_ok = 1'b0;
		if (seen_cnt == SECOND_START_POS && b != START_MARK)
			markers_ok = 1'b0;
		if (p >= 1 && p <= ADDR_BYTES && b != addr_reg[8*(p-1) +: 8])
			addr_ok = 1'b0;
		if (seen_cnt == CONTROL_POS)
			ctrl_seen = b;
		if (last_flag) begin
			if (p + 1 < MIN_FRAME)
				v.status = ST_SHORT;
			else if (!markers_ok || b != STOP_MARK)
				v.status = ST_MARKERS;
			else if (sum_acc != hist[0])
				v.status = ST_CHECKSUM;
			else if (!ctrl_seen[DIR_BIT])
				v.status = ST_DIRECTION;
			else if (ctrl_seen[ABNORMAL_BIT]) begin
				v.status = ST_ABNORMAL;
				v.err = hist[1];
			end else if (!addr_ok)
				v.status = ST_ADDRESS;
			clear_frame_state();
			return 1'b1;
		end
		sum_acc = sum_acc + hist[0];
		hist[2] = hist[1];
		hist[1] = hist[0];
		hist[0] = b;
		if (seen_cnt != POS_MAX)
			seen_cnt = seen_cnt + 4'd1;
		return 1'b0;
	endfunction

	function automatic int unsigned pick_idle();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [BYTE_W-1:0] nonzero_flip();
		return BYTE_W'($urandom_range(1, 255));
	endfunction

	function automatic void build_frame(input recipe_t rc, ref logic [BYTE_W-1:0] q[$]);
		logic [BYTE_W-1:0] acc;
		int idx;
		q.delete();
		for (int i = 0; i < rc.len; i++)
			q.push_back(rc.rand_data ? BYTE_W'($urandom_range(0, 255)) : rc.fill);
		if (rc.noise)
			return;
		q[0] = START_MARK;
		for (int i = 1; i <= ADDR_BYTES && i < rc.len; i++)
			q[i] = addr_reg[8*(i-1) +: 8];
		if (rc.len > SECOND_START_POS)
			q[SECOND_START_POS] = START_MARK;
		if (rc.len > CONTROL_POS)
			q[CONTROL_POS] = rc.ctrl;
		if (rc.len >= MIN_FRAME)
			q[CONTROL_POS + 1] = BYTE_W'(rc.len - MIN_FRAME);
		if (rc.bad_addr && rc.len > ADDR_BYTES) begin
			idx = $urandom_range(1, ADDR_BYTES);
			q[idx] = q[idx] ^ nonzero_flip();
		end
		if (rc.len >= MIN_FRAME) begin
			acc = '0;
			for (int i = 0; i < rc.len - 2; i++)
				acc = acc + q[i];
			q[rc.len-2] = acc;
			q[rc.len-1] = STOP_MARK;
			if (rc.bad_sum)
				q[rc.len-2] = acc ^ nonzero_flip();
			if (rc.bad_stop)
				q[rc.len-1] = STOP_MARK ^ nonzero_flip();
		end
		if (rc.bad_first)
			q[0] = START_MARK ^ nonzero_flip();
		if (rc.bad_second && rc.len > SECOND_START_POS)
			q[SECOND_START_POS] = START_MARK ^ nonzero_flip();
	endfunction

	function automatic recipe_t random_recipe();
		recipe_t rc;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			rc.len = $urandom_range(1, MIN_FRAME - 1);
		else if (r < 16)
			rc.len = $urandom_range(17, 30);
		else
			rc.len = $urandom_range(MIN_FRAME, 16);
		rc.ctrl = BYTE_W'($urandom_range(0, 255));
		rc.ctrl[DIR_BIT] = ($urandom_range(0, 9) != 0);
		rc.ctrl[ABNORMAL_BIT] = ($urandom_range(0, 5) == 0);
		rc.fill = '0;
		rc.noise = ($urandom_range(0, 19) == 0);
		rc.rand_data = 1'b1;
		rc.bad_addr = ($urandom_range(0, 7) == 0);
		rc.bad_first = ($urandom_range(0, 11) == 0);
		rc.bad_second = ($urandom_range(0, 11) == 0);
		rc.bad_stop = ($urandom_range(0, 11) == 0);
		rc.bad_sum = ($urandom_range(0, 11) == 0);
		rc.typed = 1'b0;
		rc.status = ST_OK;
		rc.err = '0;
		return rc;
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit last_flag,
			input bit typed, input verdict_t typed_v);
		verdict_t v;
		int unsigned gap;
		in_ch.valid <= 1'b1;
		in_ch.frame_byte <= b;
		in_ch.is_last <= last_flag;
		do @(posedge clk); while (!in_ch.ready);
		if (judge_byte(b, last_flag, v))
			pending_verdicts.push_back(typed ? typed_v : v);
		gap = pick_idle();
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(input recipe_t rc);
		logic [BYTE_W-1:0] q [$];
		verdict_t tv;
		tv.status = rc.status;
		tv.err = rc.err;
		build_frame(rc, q);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1, rc.typed, tv);
	endtask

	task automatic send_random_frames(input int unsigned n_words);
		int unsigned sent;
		recipe_t rc;
		sent = 0;
		while (sent < n_words) begin
			rc = random_recipe();
			send_frame(rc);
			sent += rc.len;
		end
	endtask

	task automatic wait_verdicts_drained();
		in_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_station_address(input logic [ADDR_W-1:0] value);
		wait_verdicts_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.station_address <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		addr_reg = value;
	endtask

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : result_side
		int unsigned stall_left;
		int unsigned n;
		verdict_t want;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (out_ch.valid && out_ch.ready) begin
					if (pending_verdicts.size() == 0)
						report_mismatch("result word with no verdict pending");
					else begin
						want = pending_verdicts.pop_front();
						if (out_ch.status !== want.status)
							report_mismatch($sformatf("status %0d, want %s",
								out_ch.status, want.status.name()));
						if (out_ch.error_byte !== want.err)
							report_mismatch($sformatf("error_byte %02h, want %02h",
								out_ch.error_byte, want.err));
					end
				end
				if (stall_left != 0) begin
					out_ch.ready <= 1'b0;
					stall_left--;
				end else if (hold_req) begin
					hold_req = 1'b0;
					out_ch.ready <= 1'b0;
					stall_left = LONG_HOLD - 1;
				end else begin
					n = pick_idle();
					out_ch.ready <= (n == 0);
					if (n != 0)
						stall_left = n - 1;
				end
			end
		end
	end

	initial begin : stimulus
		logic [ADDR_W-1:0] a;
		fail_count = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		addr_reg = '0;
		clear_frame_state();
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.frame_byte <= '0;
		in_ch.is_last <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.station_address <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_frames[i])
			send_frame(directed_frames[i]);

		write_station_address({ADDR_W{1'b1}});
		send_random_frames(110);

		a = ADDR_W'({$urandom, $urandom});
		write_station_address(a);
		no_idle = 1'b1;
		send_random_frames(80);
		// hold the result side while words keep coming
		hold_req = 1'b1;
		send_random_frames(50);
		no_idle = 1'b0;
		wait_verdicts_drained();
		send_random_frames(100);

		write_station_address('0);
		send_random_frames(70);

		wait_verdicts_drained();
		repeat (10) @(posedge clk);
		if (pending_verdicts.size() != 0)
			report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: meter_reply_frame_checker_top.f
+incdir+hw/rtl
hw/rtl/mrfc_pkg.sv
hw/rtl/mrfc_if.sv
hw/rtl/meter_reply_frame_checker_top.sv
dv/testbench.sv
